[rtl/core/css_pkg.sv]
// ----------------------------------------------------------------------------
// css_pkg
// shared types and constants of the closest subarray sum search
// ----------------------------------------------------------------------------
`default_nettype none

package css_pkg;

  localparam int MaxLen    = 1024;
  localparam int ElemWidth = 16;
  localparam int IdxW      = $clog2(MaxLen + 1);
  localparam int PosW      = 11;
  localparam int SumW      = 27;
  localparam int TgtW      = 30;
  localparam int BestW     = 26;
  localparam int QDepth    = 2;

  typedef enum logic [1:0] {
    ReqClear  = 2'd0,
    ReqAppend = 2'd1,
    ReqQuery  = 2'd2,
    ReqNone   = 2'd3
  } req_e;

  // classified command passed from front to back
  typedef struct packed {
    req_e                  op;
    logic signed [SumW-1:0] psum;
    logic [IdxW-1:0]       idx;
    logic [TgtW-1:0]       tgt;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/core/css_front.sv]
// ----------------------------------------------------------------------------
// css_front
// accepts requests, keeps running total and count, queues commands
// ----------------------------------------------------------------------------
`default_nettype none

module css_front (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire  [1:0]               req_type_i,
  input  wire  signed [15:0]       element_value_i,
  input  wire  [29:0]              target_i,
  input  wire                      valid_i,
  output logic                     ready_o,
  output css_pkg::cmd_t            cmd_o,
  output logic                     cmd_valid_o,
  input  wire                      cmd_ready_i
);

  css_pkg::cmd_t                          q_mem [css_pkg::QDepth];
  logic                                   wp_q, rp_q;
  logic [1:0]                             cnt_q;
  logic [css_pkg::IdxW-1:0]               count_q;
  logic signed [css_pkg::SumW-1:0]        total_q;
  logic                                   push, pop, drop;
  css_pkg::cmd_t                          cmd;
  logic signed [css_pkg::SumW-1:0]        nsum;

  assign ready_o     = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rp_q];
  assign pop         = cmd_valid_o && cmd_ready_i;

  // classify request
  always_comb begin
    nsum     = total_q + css_pkg::SumW'(element_value_i);
    cmd.op   = css_pkg::req_e'(req_type_i);
    cmd.psum = nsum;
    cmd.idx  = count_q + 1'b1;
    cmd.tgt  = target_i;
    drop     = (cmd.op == css_pkg::ReqNone) ||
               (cmd.op == css_pkg::ReqAppend &&
                count_q == css_pkg::IdxW'(css_pkg::MaxLen));
    push     = valid_i && ready_o && !drop;
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
      count_q <= '0; total_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
      if (push && cmd.op == css_pkg::ReqClear) begin
        count_q <= '0; total_q <= '0;
      end else if (push && cmd.op == css_pkg::ReqAppend) begin
        count_q <= cmd.idx; total_q <= nsum;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/css_back.sv]
// ----------------------------------------------------------------------------
// css_back
// prefix memory, insertion sort and two-pointer walk
// ----------------------------------------------------------------------------
`default_nettype none

module css_back (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire css_pkg::cmd_t       cmd_i,
  input  wire                      cmd_valid_i,
  output logic                     cmd_ready_o,
  output logic                     found_o,
  output logic [25:0]              best_sum_o,
  output logic [10:0]              start_position_o,
  output logic [10:0]              end_position_o,
  output logic                     valid_o,
  input  wire                      ready_i
);

  localparam int IW = css_pkg::IdxW;
  localparam int SW = css_pkg::SumW;
  localparam int TW = css_pkg::TgtW;
  localparam int EW = SW + IW;

  typedef enum logic [3:0] {
    SIdle, SsLoad, SsRd, SsCmp, SwRdLo, SwRdHi, SwEval, SwDecide, SDone
  } state_e;

  logic [EW-1:0]         mem [css_pkg::MaxLen + 1];
  logic [EW-1:0]         rd_q;
  state_e                st_q;
  logic [IW-1:0]         n_q, i_q, j_q, lo_q, hi_q;
  logic [EW-1:0]         key_q, elo_q;
  logic                  sorted_q, below_q, have_q;
  logic signed [SW-1:0]  cur_q, best_q;
  logic [TW:0]           bdist_q;
  logic [TW-1:0]         tgt_q;
  logic [IW-1:0]         from_q, to_q;
  logic                  wr_en;
  logic [IW-1:0]         wr_a, rd_a;
  logic [EW-1:0]         wr_d;
  logic                  key_less;
  logic signed [SW-1:0]  diff;
  logic signed [TW+1:0]  dd;
  logic [TW:0]           delta;
  logic                  cur_lt;
  logic [IW-1:0]         pa, pb;

  // clear and append also go in while a result waits
  assign cmd_ready_o = (st_q == SIdle);

  // entry ordering by sum then position, and walk difference and target distance
  always_comb begin
    key_less = ($signed(key_q[EW-1:IW]) < $signed(rd_q[EW-1:IW])) ||
               (key_q[EW-1:IW] == rd_q[EW-1:IW] && key_q[IW-1:0] < rd_q[IW-1:0]);
    diff   = $signed(rd_q[EW-1:IW]) - $signed(elo_q[EW-1:IW]);
    dd     = $signed({2'b00, tgt_q}) - (TW+2)'(diff);
    delta  = dd[TW+1] ? (TW+1)'(-dd) : dd[TW:0];
    cur_lt = $signed({1'b0, tgt_q}) > (TW+1)'(cur_q);
    pa     = elo_q[IW-1:0];
    pb     = rd_q[IW-1:0];
  end

  // memory port control
  always_comb begin
    wr_en = 1'b0; wr_a = '0; wr_d = '0; rd_a = i_q;
    case (st_q)
      SIdle: begin
        if (cmd_valid_i && cmd_ready_o) begin
          if (cmd_i.op == css_pkg::ReqClear) begin
            wr_en = 1'b1; wr_a = '0; wr_d = '0;
          end else if (cmd_i.op == css_pkg::ReqAppend) begin
            wr_en = 1'b1; wr_a = cmd_i.idx; wr_d = {cmd_i.psum, cmd_i.idx};
          end
        end
      end
      SsRd:    rd_a = j_q - 1'b1;
      SsCmp: begin
        wr_en = 1'b1;
        if (j_q != '0 && key_less) begin
          wr_a = j_q; wr_d = rd_q;
        end else begin
          wr_a = j_q; wr_d = key_q;
        end
      end
      SwRdLo:  rd_a = lo_q;
      SwRdHi:  rd_a = hi_q;
      default: rd_a = i_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_a] <= wr_d;
    rd_q <= mem[rd_a];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; n_q <= '0; sorted_q <= 1'b0; valid_o <= 1'b0;
      i_q <= '0; j_q <= '0; lo_q <= '0; hi_q <= '0;
      below_q <= 1'b1; have_q <= 1'b0;
      key_q <= '0; elo_q <= '0; cur_q <= '0; best_q <= '0; bdist_q <= '0;
      tgt_q <= '0; from_q <= '0; to_q <= '0;
      found_o <= 1'b0; best_sum_o <= '0; start_position_o <= '0; end_position_o <= '0;
    end else begin
      if (valid_o && ready_i) valid_o <= 1'b0;
      case (st_q)
        SIdle: begin
          if (cmd_valid_i && cmd_ready_o) begin
            case (cmd_i.op)
              css_pkg::ReqClear:  begin n_q <= '0; sorted_q <= 1'b0; end
              css_pkg::ReqAppend: begin n_q <= cmd_i.idx; sorted_q <= 1'b0; end
              css_pkg::ReqQuery: begin
                tgt_q <= cmd_i.tgt;
                lo_q <= '0; hi_q <= '0; below_q <= 1'b1; have_q <= 1'b0;
                best_q <= '0; from_q <= '0; to_q <= '0; cur_q <= '0;
                i_q <= IW'(1);
                st_q <= sorted_q ? SwDecide : SsLoad;
              end
              default: st_q <= SIdle;
            endcase
          end
        end
        // insertion sort: key load, then shift down one entry a pass
        SsLoad: begin
          if (i_q > n_q) begin
            sorted_q <= 1'b1; st_q <= SwDecide;
          end else begin
            j_q <= i_q; st_q <= SsRd;
          end
        end
        SsRd: begin
          if (j_q == i_q) key_q <= rd_q;
          st_q <= SsCmp;
        end
        SsCmp: begin
          if (j_q != '0 && key_less) begin
            j_q <= j_q - 1'b1; st_q <= SsRd;
          end else begin
            i_q <= i_q + 1'b1; st_q <= SsLoad;
          end
        end
        // two-pointer walk
        SwDecide: begin
          if (hi_q < n_q && (below_q || cur_lt)) begin
            hi_q <= hi_q + 1'b1; st_q <= SwRdLo;
          end else if (below_q || cur_lt) begin
            st_q <= SDone;
          end else begin
            lo_q <= lo_q + 1'b1; st_q <= SwRdLo;
          end
        end
        SwRdLo: st_q <= SwRdHi;
        SwRdHi: begin elo_q <= rd_q; st_q <= SwEval; end
        SwEval: begin
          if (lo_q >= hi_q) begin
            below_q <= 1'b1;
          end else begin
            cur_q <= diff; below_q <= 1'b0;
            if (!have_q || delta < bdist_q) begin
              have_q <= 1'b1; best_q <= diff; bdist_q <= delta;
              from_q <= (pa < pb) ? pa : pb;
              to_q   <= (pa < pb) ? pb : pa;
            end
          end
          st_q <= SwDecide;
        end
        SDone: begin
          if (!valid_o) begin
            valid_o <= 1'b1;
            found_o <= have_q;
            best_sum_o <= have_q ? best_q[25:0] : '0;
            start_position_o <= have_q ? 11'(from_q + 1'b1) : '0;
            end_position_o <= have_q ? 11'(to_q) : '0;
            st_q <= SIdle;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/closest_subarray_sum_search.sv]
// ----------------------------------------------------------------------------
// closest_subarray_sum_search
// closest nonnegative subarray sum to a target over a loaded sequence
// ----------------------------------------------------------------------------
// Clear and append requests are queued in a two-entry command queue; appends
// flow at one per cycle while the back end drains them, also while a query
// result waits to be taken. A query after a change runs an insertion sort over
// the n+1 prefix entries in the prefix memory (O(n^2) shifts worst case), then a
// two-pointer walk of at most 2n steps, each through the decide, low read, high
// read and evaluate states; a repeated query skips the sort.
// No clearing pass is needed.
`default_nettype none

module closest_subarray_sum_search (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire  [1:0]         req_type_i,
  input  wire  signed [15:0] element_value_i,
  input  wire  [29:0]        target_i,
  input  wire                valid_i,
  output logic               ready_o,
  output logic               found_o,
  output logic [25:0]        best_sum_o,
  output logic [10:0]        start_position_o,
  output logic [10:0]        end_position_o,
  output logic               valid_o,
  input  wire                ready_i
);

  css_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_ready;

  // request front
  css_front u_front (
    .clk_i, .rst_ni, .req_type_i, .element_value_i, .target_i, .valid_i,
    .ready_o, .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready)
  );

  // search back end
  css_back u_back (
    .clk_i, .rst_ni, .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .found_o, .best_sum_o, .start_position_o, .end_position_o, .valid_o, .ready_i
  );

endmodule

`default_nettype wire

[rtl/core/css_checker.sv]
// ----------------------------------------------------------------------------
// css_checker
// port-level checks of the closest subarray sum search
// ----------------------------------------------------------------------------
`default_nettype none

module css_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        valid_o,
  input wire        ready_i,
  input wire        found_o,
  input wire [25:0] best_sum_o,
  input wire [10:0] start_position_o,
  input wire [10:0] end_position_o
);

  // result holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(best_sum_o))
    else $error("result changed under stall");

  // not found reports zero fields
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !found_o |-> best_sum_o == '0 && start_position_o == '0)
    else $error("empty result not zero");

  // found range is ordered and nonempty
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && found_o |-> start_position_o != '0 && start_position_o <= end_position_o)
    else $error("bad range");

endmodule

bind closest_subarray_sum_search css_checker u_chk (
  .clk_i, .rst_ni, .valid_o, .ready_i, .found_o, .best_sum_o,
  .start_position_o, .end_position_o
);

`default_nettype wire

[tb/sv/css_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// css_scoreboard
// watches both channels of the closest subarray sum search, predicts each
// query answer from its own copy of the prefix table and compares results
// ----------------------------------------------------------------------------
`default_nettype none

module css_scoreboard (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire  [1:0]  req_type_i,
  input  wire  [15:0] element_value_i,
  input  wire  [29:0] target_i,
  input  wire         valid_i,
  input  wire         ready_o,
  input  wire         found_o,
  input  wire  [25:0] best_sum_o,
  input  wire  [10:0] start_position_o,
  input  wire  [10:0] end_position_o,
  input  wire         valid_o,
  input  wire         ready_i,
  output int          errors_o,
  output int          pending_o,
  output int          answers_o,
  output int          hits_o
);

  typedef struct {
    logic        found;
    logic [25:0] best_sum;
    logic [10:0] start_pos;
    logic [10:0] end_pos;
  } answer_t;

  // shadow prefix table
  longint  psum_tab [0:css_pkg::MaxLen];
  int      ppos_tab [0:css_pkg::MaxLen];
  int      elem_cnt;
  longint  run_total;
  bit      tab_sorted;
  answer_t answer_q [$];

  assign pending_o = answer_q.size();

  // insertion sort by (sum, position)
  function automatic void sort_table();
    longint ks;
    int     kp;
    int     j;
    for (int i = 1; i <= elem_cnt; i++) begin
      ks = psum_tab[i];
      kp = ppos_tab[i];
      j  = i;
      while (j > 0 && (ks < psum_tab[j-1] || (ks == psum_tab[j-1] && kp < ppos_tab[j-1]))) begin
        psum_tab[j] = psum_tab[j-1];
        ppos_tab[j] = ppos_tab[j-1];
        j--;
      end
      psum_tab[j] = ks;
      ppos_tab[j] = kp;
    end
  endfunction

  // two-pointer walk for the closest nonnegative range sum
  function automatic answer_t closest_range(longint tgt);
    answer_t a;
    int      lo;
    int      hi;
    bit      below;
    bit      have;
    longint  cur;
    longint  best;
    longint  best_dist;
    longint  d;
    int      from;
    int      to;
    lo = 0; hi = 0; below = 1; have = 0; cur = 0; best = 0; best_dist = 0;
    from = 0; to = 0;
    if (!tab_sorted) begin
      sort_table();
      tab_sorted = 1;
    end
    forever begin
      if (hi < elem_cnt && (below || cur < tgt)) begin
        hi++;
      end else if (below || cur < tgt) begin
        break;
      end else begin
        lo++;
      end
      if (lo >= hi) begin
        below = 1;
      end else begin
        cur   = psum_tab[hi] - psum_tab[lo];
        below = 0;
        d     = tgt - cur;
        if (d < 0) d = -d;
        if (!have || d < best_dist) begin
          have = 1;
          best = cur;
          best_dist = d;
          from = (ppos_tab[lo] < ppos_tab[hi]) ? ppos_tab[lo] : ppos_tab[hi];
          to   = (ppos_tab[lo] < ppos_tab[hi]) ? ppos_tab[hi] : ppos_tab[lo];
        end
      end
    end
    a.found     = have;
    a.best_sum  = have ? best[25:0] : '0;
    a.start_pos = have ? 11'(from + 1) : '0;
    a.end_pos   = have ? 11'(to) : '0;
    return a;
  endfunction

  // request side: update shadow state, queue query answers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_cnt    = 0;
      run_total   = 0;
      tab_sorted  = 0;
      psum_tab[0] = 0;
      ppos_tab[0] = 0;
    end else if (valid_i && ready_o) begin
      case (css_pkg::req_e'(req_type_i))
        css_pkg::ReqClear: begin
          elem_cnt    = 0;
          run_total   = 0;
          tab_sorted  = 0;
          psum_tab[0] = 0;
          ppos_tab[0] = 0;
        end
        css_pkg::ReqAppend: begin
          if (elem_cnt < css_pkg::MaxLen) begin
            run_total += longint'($signed(element_value_i));
            elem_cnt++;
            psum_tab[elem_cnt] = run_total;
            ppos_tab[elem_cnt] = elem_cnt;
            tab_sorted = 0;
          end
        end
        css_pkg::ReqQuery: answer_q.push_back(closest_range(longint'(target_i)));
        default: ;
      endcase
    end
  end

  // result side: compare against the oldest answer
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t e;
    if (!rst_ni) begin
      errors_o  <= 0;
      answers_o <= 0;
      hits_o    <= 0;
    end else if (valid_o && ready_i) begin
      answers_o <= answers_o + 1;
      if (found_o) hits_o <= hits_o + 1;
      if (answer_q.size() == 0) begin
        if (errors_o < 10) $display("%0t: unexpected result found=%0b sum=%0d range=%0d..%0d",
                                    $time, found_o, best_sum_o, start_position_o,
                                    end_position_o);
        errors_o <= errors_o + 1;
      end else begin
        e = answer_q.pop_front();
        if (e.found !== found_o || e.best_sum !== best_sum_o ||
            e.start_pos !== start_position_o || e.end_pos !== end_position_o) begin
          if (errors_o < 10)
            $display("%0t: mismatch exp found=%0b sum=%0d range=%0d..%0d, got %0b %0d %0d..%0d",
                     $time, e.found, e.best_sum, e.start_pos, e.end_pos, found_o,
                     best_sum_o, start_position_o, end_position_o);
          errors_o <= errors_o + 1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the closest subarray sum search
// ----------------------------------------------------------------------------
// Loads short signed sequences and queries them with random targets, plus
// directed extremes (empty sequence, full sequence, unused request code,
// appends after a query), under several sender and receiver idle patterns.
`default_nettype none

module testbench;

  localparam int CycleLimit = 4000000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic [1:0]  req_type_i = css_pkg::ReqNone;
  logic [15:0] element_value_i = '0;
  logic [29:0] target_i = '0;
  logic        valid_i = 0;
  logic        ready_i = 0;
  wire         ready_o, found_o, valid_o;
  wire  [25:0] best_sum_o;
  wire  [10:0] start_position_o, end_position_o;
  int          errors, pending, answers, hits;
  int          send_idle_pct, recv_stall_pct;
  bit          hold_off;
  int          cycles;
  int          sent;

  always #5 clk_i = ~clk_i;

  closest_subarray_sum_search dut (
    .clk_i, .rst_ni, .req_type_i, .element_value_i, .target_i, .valid_i, .ready_o,
    .found_o, .best_sum_o, .start_position_o, .end_position_o, .valid_o, .ready_i
  );

  css_scoreboard u_checker (
    .clk_i, .rst_ni, .req_type_i, .element_value_i, .target_i, .valid_i, .ready_o,
    .found_o, .best_sum_o, .start_position_o, .end_position_o, .valid_o, .ready_i,
    .errors_o(errors), .pending_o(pending), .answers_o(answers), .hits_o(hits)
  );

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    bit held;
    held = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off && !held) begin
        ready_i <= 0;
        repeat (3000) @(negedge clk_i);
        held = 1;
      end
      ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one request, held until accepted
  task automatic send_request(css_pkg::req_e op, logic [15:0] val, logic [29:0] tgt);
    bit acc;
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 0;
      @(negedge clk_i);
    end
    valid_i         <= 1;
    req_type_i      <= op;
    element_value_i <= val;
    target_i        <= tgt;
    acc = 0;
    while (!acc) begin
      #1 acc = ready_o;
      @(negedge clk_i);
    end
    sent++;
  endtask

  function automatic logic [29:0] pick_target();
    case ($urandom_range(3))
      0: return 30'($urandom);
      1: return 30'($urandom_range(300));
      default: return 30'($urandom_range(200000));
    endcase
  endfunction

  function automatic logic [15:0] pick_value();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($urandom_range(200) - 100);
  endfunction

  initial begin
    int n;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off       = 0;
    sent           = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: empty, extremes, unused code, append after query
    send_request(css_pkg::ReqQuery, '0, 30'h3fffffff);
    send_request(css_pkg::ReqClear, '0, '0);
    send_request(css_pkg::ReqQuery, '0, '0);
    send_request(css_pkg::ReqAppend, 16'h7fff, '0);
    send_request(css_pkg::ReqAppend, 16'h8000, '0);
    send_request(css_pkg::ReqAppend, 16'h0000, '0);
    send_request(css_pkg::ReqAppend, 16'hffff, '0);
    send_request(css_pkg::ReqQuery, '0, '0);
    send_request(css_pkg::ReqQuery, '0, 30'h3fffffff);
    send_request(css_pkg::ReqNone, 16'hffff, 30'h3fffffff);
    send_request(css_pkg::ReqQuery, '0, 30'd32767);
    send_request(css_pkg::ReqAppend, 16'd5, '0);
    send_request(css_pkg::ReqQuery, '0, 30'd1);
    send_request(css_pkg::ReqClear, '0, '0);

    // full sequence of the largest element, then one ignored append
    for (int i = 0; i < css_pkg::MaxLen + 1; i++)
      send_request(css_pkg::ReqAppend, 16'h7fff, '0);
    send_request(css_pkg::ReqQuery, '0, 30'h3fffffff);
    send_request(css_pkg::ReqQuery, '0, 30'd5);
    send_request(css_pkg::ReqClear, '0, '0);

    // random sequences across idle phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 8 : 60) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 8 : 60) : 0;
      if (ph == 0) hold_off = 1;
      for (int s = 0; s < 8; s++) begin
        if ($urandom_range(9) == 0)
          send_request(css_pkg::ReqNone, 16'($urandom), 30'($urandom));
        send_request(css_pkg::ReqClear, 16'($urandom), 30'($urandom));
        n = $urandom_range(30);
        for (int k = 0; k < n; k++)
          send_request(css_pkg::ReqAppend, pick_value(), 30'($urandom));
        for (int q = $urandom_range(4, 1); q > 0; q--) begin
          send_request(css_pkg::ReqQuery, 16'($urandom), pick_target());
          if ($urandom_range(3) == 0) send_request(css_pkg::ReqAppend, pick_value(), '0);
        end
      end
    end
    valid_i <= 0;

    wait (pending == 0);
    repeat (100) @(posedge clk_i);
    $display("run: %0d requests sent, %0d query results checked (%0d with a range found)",
             sent, answers, hits);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
